// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Invariant.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

// ----- hdl/eadsr_pkg.sv -----
// Shared constants, codes and helpers of the exponential ADSR envelope.
package eadsr_pkg;

   localparam int LEVEL_WIDTH    = 24;
   localparam int SAMPLE_WIDTH   = 24;
   localparam int COEFF_WIDTH    = 24;
   localparam int SUSTAIN_WIDTH  = 23;
   localparam int FLAGS_WIDTH    = 2;
   localparam int LEVEL_FRAC     = 22;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int MUL_WIDTH      = 25;
   localparam int PROD_WIDTH     = 2 * MUL_WIDTH;
   localparam int WIDE_WIDTH     = 28;

   typedef logic signed [LEVEL_WIDTH-1:0]  level_type;
   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [COEFF_WIDTH-1:0]         coeff_type;
   typedef logic signed [MUL_WIDTH-1:0]    mul_op_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [WIDE_WIDTH-1:0]   wide_type;
   typedef logic [2:0]                     phase_type;
   typedef logic [1:0]                     action_type;

   localparam phase_type PH_IDLE    = 3'd0;
   localparam phase_type PH_ATTACK  = 3'd1;
   localparam phase_type PH_DECAY   = 3'd2;
   localparam phase_type PH_SUSTAIN = 3'd3;
   localparam phase_type PH_RELEASE = 3'd4;

   localparam action_type ACT_TICK     = 2'd0;
   localparam action_type ACT_NOTE_ON  = 2'd1;
   localparam action_type ACT_NOTE_OFF = 2'd2;
   localparam action_type ACT_RESET    = 2'd3;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_ATTACK_COEFF   = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_ATTACK_OFFSET  = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_DECAY_COEFF    = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_DECAY_OFFSET   = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RELEASE_COEFF  = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RELEASE_OFFSET = 3'd5;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_SUSTAIN_LEVEL  = 3'd6;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_ZERO_TIME      = 3'd7;

   localparam level_type LEVEL_ONE  = 24'sh400000;
   localparam level_type LEVEL_ZERO = 24'sh000000;
   localparam logic [SUSTAIN_WIDTH-1:0] SUSTAIN_RESET = 23'd3355443;

   localparam wide_type SAT_HI = 28'sh07FFFFF;
   localparam wide_type SAT_LO = 28'shF800000;

   // Clamp a wide signed value to the 24-bit signed range.
   function automatic level_type sat24(input wide_type v);
      level_type r;
      if (v > SAT_HI) begin
         r = SAT_HI[LEVEL_WIDTH-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[LEVEL_WIDTH-1:0];
      end else begin
         r = v[LEVEL_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/eadsr_req_if.sv -----
// Request channel interface: action and sample in.
interface eadsr_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [1:0]                               action;
   logic signed [eadsr_pkg::SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output action, output sample_in, input ready);
   modport sink (input valid, input action, input sample_in, output ready);
endinterface

// ----- hdl/eadsr_rsp_if.sv -----
// Response channel interface: level, phase and scaled sample out.
interface eadsr_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [eadsr_pkg::LEVEL_WIDTH-1:0]  envelope_level;
   logic [2:0]                               phase;
   logic signed [eadsr_pkg::SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, output envelope_level, output phase, output sample_out,
                   input ready);
   modport sink (input valid, input envelope_level, input phase, input sample_out,
                 output ready);
endinterface

// ----- hdl/eadsr_mul.sv -----
// Shared signed multiplier with registered product.
module eadsr_mul (
   input  logic                                   clock,
   input  logic signed [eadsr_pkg::MUL_WIDTH-1:0]  op_a,
   input  logic signed [eadsr_pkg::MUL_WIDTH-1:0]  op_b,
   output logic signed [eadsr_pkg::PROD_WIDTH-1:0] prod
);
   import eadsr_pkg::*;

   prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ----- hdl/exponential_adsr_envelope_top.sv -----
// Exponential ADSR envelope top level: sequencer, state and config registers.
// A tick in attack, decay or release steps through ST_SEG, ST_UPD, ST_SMP and ST_OUT; a tick in
// idle or sustain through ST_SMP and ST_OUT; note on, note off and reset through ST_CMD.
// Only one transaction is in flight at a time: the single shared 25x25 multiplier (segment
// product, then sample product) and its sequencer take no new request until the response is loaded.
// Reset (synchronous, active high): phase idle, level 0, registers to defaults.
`include "assert_macros.svh"
module exponential_adsr_envelope_top (
   input  logic                                     clock,
   input  logic                                     reset,
   eadsr_req_if.sink                                req_chan,
   eadsr_rsp_if.source                              rsp_chan,
   input  logic                                     csr_we,
   input  logic [eadsr_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [eadsr_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import eadsr_pkg::*;

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;  // ready for a transaction
   localparam logic [2:0] ST_SEG  = 3'd1;  // level * coeff in the multiplier
   localparam logic [2:0] ST_UPD  = 3'd2;  // add offset, saturate, phase change
   localparam logic [2:0] ST_SMP  = 3'd3;  // sample * new level in the multiplier
   localparam logic [2:0] ST_OUT  = 3'd4;  // scale, saturate, load response
   localparam logic [2:0] ST_CMD  = 3'd5;  // note on / note off / reset

   // Configuration registers
   coeff_type                  atk_coeff_ff, dec_coeff_ff, rel_coeff_ff;
   level_type                  atk_off_ff, dec_off_ff, rel_off_ff;
   logic [SUSTAIN_WIDTH-1:0]   sustain_ff;
   logic [FLAGS_WIDTH-1:0]     flags_ff;

   // Sequencer and envelope state
   logic [2:0]  state_ff, state_in;
   action_type  action_ff, action_in;
   sample_type  smp_ff, smp_in;
   level_type   level_ff, level_in;
   phase_type   phase_ff, phase_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   level_type   rsp_level_ff, rsp_level_in;
   phase_type   rsp_phase_ff, rsp_phase_in;
   sample_type  rsp_sample_ff, rsp_sample_in;

   logic        accept;
   logic        out_free;
   logic        rsp_load;
   logic        zero_attack, zero_release;
   logic        active_phase;
   logic        was_idle;

   mul_op_type  op_a, op_b;
   prod_type    prod;

   coeff_type   coeff_sel;
   level_type   offset_sel;
   logic signed [COEFF_WIDTH+1:0] seg_shift;
   wide_type    seg_sum;
   level_type   seg_level;
   level_type   scaled;
   level_type   cmd_level;
   phase_type   cmd_phase;

   assign zero_attack  = flags_ff[0];
   assign zero_release = flags_ff[1];
   assign active_phase = (phase_ff == PH_ATTACK) || (phase_ff == PH_DECAY) ||
                         (phase_ff == PH_RELEASE);
   // Out-of-range codes count as idle.
   assign was_idle     = !(phase_ff inside {PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE});

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Segment parameters follow the current phase.
   always_comb begin
      case (phase_ff)
         PH_ATTACK: begin
            coeff_sel  = atk_coeff_ff;
            offset_sel = atk_off_ff;
         end
         PH_DECAY: begin
            coeff_sel  = dec_coeff_ff;
            offset_sel = dec_off_ff;
         end
         default: begin
            coeff_sel  = rel_coeff_ff;
            offset_sel = rel_off_ff;
         end
      endcase
   end

   // Operand select for the shared multiplier; the sample product is held
   // while the output stage waits for a free response slot.
   always_comb begin
      case (state_ff)
         ST_SMP, ST_OUT: begin
            op_a = {smp_ff[SAMPLE_WIDTH-1], smp_ff};
            op_b = {level_ff[LEVEL_WIDTH-1], level_ff};
         end
         default: begin
            op_a = {level_ff[LEVEL_WIDTH-1], level_ff};
            op_b = {1'b0, coeff_sel};
         end
      endcase
   end

   eadsr_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Segment: floor(level*coeff / 2^24) + offset, saturated.
   assign seg_shift = prod[PROD_WIDTH-1:COEFF_WIDTH];
   assign seg_sum   = {{(WIDE_WIDTH-COEFF_WIDTH-2){seg_shift[COEFF_WIDTH+1]}}, seg_shift} +
                      {{(WIDE_WIDTH-LEVEL_WIDTH){offset_sel[LEVEL_WIDTH-1]}}, offset_sel};
   assign seg_level = sat24(seg_sum);

   // Sample: floor(sample*level / 2^22), saturated.
   assign scaled = sat24(prod[PROD_WIDTH-1:LEVEL_FRAC]);

   // Note on / note off / reset actions.
   always_comb begin
      cmd_level = level_ff;
      cmd_phase = phase_ff;
      case (action_ff)
         ACT_NOTE_ON: begin
            cmd_phase = zero_attack ? PH_DECAY : PH_ATTACK;
            if (was_idle) begin
               cmd_level = zero_attack ? LEVEL_ONE : LEVEL_ZERO;
            end
         end
         ACT_NOTE_OFF: begin
            cmd_phase = (level_ff > LEVEL_ZERO) ? PH_RELEASE : PH_IDLE;
         end
         default: begin
            cmd_phase = PH_IDLE;
            cmd_level = LEVEL_ZERO;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      smp_in        = smp_ff;
      level_in      = level_ff;
      phase_in      = phase_ff;
      rsp_load      = 1'b0;
      rsp_level_in  = rsp_level_ff;
      rsp_phase_in  = rsp_phase_ff;
      rsp_sample_in = rsp_sample_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               action_in = req_chan.action;
               smp_in    = req_chan.sample_in;
               if (req_chan.action != ACT_TICK) begin
                  state_in = ST_CMD;
               end else if (active_phase) begin
                  state_in = ST_SEG;
               end else begin
                  state_in = ST_SMP;
               end
            end
         end
         ST_SEG: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            level_in = seg_level;
            case (phase_ff)
               PH_ATTACK: begin
                  if (seg_level >= LEVEL_ONE || zero_attack) begin
                     level_in = LEVEL_ONE;
                     phase_in = PH_DECAY;
                  end
               end
               PH_DECAY: begin
                  if (seg_level <= $signed({1'b0, sustain_ff})) begin
                     phase_in = PH_SUSTAIN;
                  end
               end
               default: begin
                  if (seg_level <= LEVEL_ZERO || zero_release) begin
                     level_in = LEVEL_ZERO;
                     phase_in = PH_IDLE;
                  end
               end
            endcase
            state_in = ST_SMP;
         end
         ST_SMP: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_level_in  = level_ff;
               rsp_phase_in  = phase_ff;
               rsp_sample_in = scaled;
               state_in      = ST_IDLE;
            end
         end
         ST_CMD: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               level_in      = cmd_level;
               phase_in      = cmd_phase;
               rsp_level_in  = cmd_level;
               rsp_phase_in  = cmd_phase;
               rsp_sample_in = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= LEVEL_ZERO;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      smp_ff        <= smp_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         atk_coeff_ff <= '0;
         atk_off_ff   <= LEVEL_ZERO;
         dec_coeff_ff <= '0;
         dec_off_ff   <= LEVEL_ZERO;
         rel_coeff_ff <= '0;
         rel_off_ff   <= LEVEL_ZERO;
         sustain_ff   <= SUSTAIN_RESET;
         flags_ff     <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_ATTACK_COEFF:   atk_coeff_ff <= csr_wdata[COEFF_WIDTH-1:0];
            REG_ATTACK_OFFSET:  atk_off_ff   <= csr_wdata[LEVEL_WIDTH-1:0];
            REG_DECAY_COEFF:    dec_coeff_ff <= csr_wdata[COEFF_WIDTH-1:0];
            REG_DECAY_OFFSET:   dec_off_ff   <= csr_wdata[LEVEL_WIDTH-1:0];
            REG_RELEASE_COEFF:  rel_coeff_ff <= csr_wdata[COEFF_WIDTH-1:0];
            REG_RELEASE_OFFSET: rel_off_ff   <= csr_wdata[LEVEL_WIDTH-1:0];
            REG_SUSTAIN_LEVEL:  sustain_ff   <= csr_wdata[SUSTAIN_WIDTH-1:0];
            REG_ZERO_TIME:      flags_ff     <= csr_wdata[FLAGS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.envelope_level = rsp_level_ff;
   assign rsp_chan.phase          = rsp_phase_ff;
   assign rsp_chan.sample_out     = rsp_sample_ff;

   // After an accepted transaction the block is not ready in the next cycle.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_chan.ready)
   // A response load always shows up as a valid response.
   `ASSERT_NEXT(a_load_shows_valid, clock, reset, rsp_load, rsp_valid_ff)
   // Commands never carry a scaled sample.
   `ASSERT_NEXT(a_cmd_sample_zero, clock, reset, rsp_load && (state_ff == ST_CMD),
                rsp_sample_ff == '0)
   // Phase stays within the defined codes.
   `ASSERT_ALWAYS(a_phase_range, clock, reset, phase_ff <= PH_RELEASE)

endmodule
